FILE: hdl/audio_sample_fifo_bridge_assert.svh
// Assertion macros for the checker file of the sample FIFO bridge.
// Depends on nothing; include by bare file name.
`ifndef AUDIO_SAMPLE_FIFO_BRIDGE_ASSERT_SVH
`define AUDIO_SAMPLE_FIFO_BRIDGE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ASFB_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("asfb assertion failed");

// Next-cycle implication, disabled during reset.
`define ASFB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("asfb assertion failed");

`endif

FILE: hdl/asfb_pkg.sv
// Package for the audio sample FIFO bridge: sizes, item codes and item types.
// Used by every module of the block but asfb_ram; depends on nothing.
package asfb_pkg;

  localparam int DEPTH        = 4096;
  localparam int SAMPLE_WIDTH = 32;
  localparam int PTR_W        = $clog2(DEPTH);
  localparam int CAP_W        = $clog2(DEPTH + 1);
  localparam int CFG_W        = 13;
  localparam int FILL_W       = 13;
  localparam int WORD_W       = 32;
  localparam int CNT_W        = 32;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [WORD_W-1:0] sample_in;
    logic              burst_last;
  } req_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] sample_out;
    logic              accepted;
    logic [FILL_W-1:0] fill_level;
    logic [CNT_W-1:0]  underrun_total;
    logic [CNT_W-1:0]  overrun_total;
    logic [CNT_W-1:0]  pushed_total;
    logic [CNT_W-1:0]  popped_total;
    logic              burst_end;
  } rsp_item_t;

  typedef struct packed {
    logic accept;
    logic wr_store;
    logic rd_store;
    logic count_overrun;
    logic count_underrun;
    logic load_rsp;
  } cmd_t;

  typedef struct packed {
    logic kind;
    logic cap_on;
    logic can_push;
    logic can_pop;
  } status_t;

endpackage

FILE: hdl/audio_sample_fifo_bridge.sv
// Audio sample FIFO bridge top level: ring FIFO of raw sample words.
// Depends on asfb_pkg, asfb_ctrl, asfb_dp (and asfb_ram below it).
//
// Usage:
//   req channel (req_valid/req_ready/req) carries one item: push or pop of
//   one 32-bit sample word, plus a marker for the last item of a batch.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns one result per item: the
//   popped word (zero on push or underrun), whether the ring took or gave
//   the word, the fill level and the four saturating counters after it.
//   cfg_wr_en/cfg_wr_data write the capacity (0 disables, 1 acts as 2,
//   above 4096 acts as 4096); a write clears pointers, fill and counters.
//   Write it only while no item is in flight.
// Timing:
//   An accepted item updates the ring and starts the registered store read;
//   the result register loads from it once rsp is free, and only then is
//   the next item taken, so one item at a time is in flight.
//   An item is accepted while the previous result still waits on rsp.
// Reset (rst, synchronous): capacity 0, ring empty, counters zero.
// Receiver stall: the result holds on rsp; at most one more item is taken,
//   and req_ready stays low until that item's result reaches rsp.
module audio_sample_fifo_bridge (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  asfb_pkg::req_item_t        req,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output asfb_pkg::rsp_item_t        rsp,
  input  logic                       cfg_wr_en,
  input  logic [asfb_pkg::CFG_W-1:0] cfg_wr_data
);
  import asfb_pkg::*;

  cmd_t    cmd;
  status_t status;

  asfb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .status    (status),
    .cmd       (cmd)
  );

  asfb_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req),
    .cmd         (cmd),
    .status      (status),
    .rsp         (rsp)
  );

endmodule

FILE: hdl/asfb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module asfb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/asfb_ctrl.sv
// Controller of the sample FIFO bridge: handshakes, item sequencing, commands.
// Depends on asfb_pkg.
module asfb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  input  asfb_pkg::status_t status,
  output asfb_pkg::cmd_t    cmd
);
  import asfb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_PEND = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   rsp_valid_next;
  logic   accept;
  logic   rsp_free;
  logic   load;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign rsp_free  = !rsp_valid || rsp_ready;
  assign load      = (state == S_PEND) && rsp_free;

  always_comb begin
    cmd.accept         = accept;
    cmd.wr_store       = accept && (status.kind == KIND_PUSH) && status.can_push;
    cmd.rd_store       = accept && (status.kind == KIND_POP) && status.can_pop;
    cmd.count_overrun  = accept && (status.kind == KIND_PUSH) && status.cap_on &&
                         !status.can_push;
    cmd.count_underrun = accept && (status.kind == KIND_POP) && !status.can_pop;
    cmd.load_rsp       = load;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_PEND;
        end
      end
      S_PEND: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (load) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

FILE: hdl/asfb_dp.sv
// Datapath of the sample FIFO bridge: capacity, pointers, fill, counters,
// sample store and result register. Depends on asfb_pkg and asfb_ram.
module asfb_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [asfb_pkg::CFG_W-1:0] cfg_wr_data,
  input  asfb_pkg::req_item_t       req,
  input  asfb_pkg::cmd_t            cmd,
  output asfb_pkg::status_t         status,
  output asfb_pkg::rsp_item_t       rsp
);
  import asfb_pkg::*;

  logic [CAP_W-1:0]        cap;
  logic [CAP_W-1:0]        cap_next;
  logic [PTR_W-1:0]        rd_ptr;
  logic [PTR_W-1:0]        wr_ptr;
  logic [CAP_W-1:0]        occ;
  logic [CNT_W-1:0]        underrun_cnt;
  logic [CNT_W-1:0]        overrun_cnt;
  logic [CNT_W-1:0]        push_cnt;
  logic [CNT_W-1:0]        pop_cnt;
  logic                    pend_took;
  logic                    pend_pop;
  logic                    pend_last;
  logic [SAMPLE_WIDTH-1:0] ram_rdata;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p,
                                               input logic [CAP_W-1:0] c);
    logic [CAP_W:0] inc;
    inc = (CAP_W + 1)'(p) + 1'b1;
    return (inc >= {1'b0, c}) ? '0 : inc[PTR_W-1:0];
  endfunction

  always_comb begin
    if (cfg_wr_data == '0) begin
      cap_next = '0;
    end else if (cfg_wr_data == CFG_W'(1)) begin
      cap_next = CAP_W'(2);
    end else if (32'(cfg_wr_data) > DEPTH) begin
      cap_next = CAP_W'(DEPTH);
    end else begin
      cap_next = CAP_W'(cfg_wr_data);
    end
  end

  always_comb begin
    status.kind     = req.kind;
    status.cap_on   = (cap != '0);
    status.can_push = (cap != '0) && (occ < cap);
    status.can_pop  = (cap != '0) && (occ != '0);
  end

  asfb_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.wr_store),
    .wr_addr (wr_ptr),
    .wr_data (SAMPLE_WIDTH'(req.sample_in)),
    .rd_en   (cmd.rd_store),
    .rd_addr (rd_ptr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cap          <= '0;
      rd_ptr       <= '0;
      wr_ptr       <= '0;
      occ          <= '0;
      underrun_cnt <= '0;
      overrun_cnt  <= '0;
      push_cnt     <= '0;
      pop_cnt      <= '0;
    end else if (cfg_wr_en) begin
      cap          <= cap_next;
      rd_ptr       <= '0;
      wr_ptr       <= '0;
      occ          <= '0;
      underrun_cnt <= '0;
      overrun_cnt  <= '0;
      push_cnt     <= '0;
      pop_cnt      <= '0;
    end else begin
      if (cmd.wr_store) begin
        wr_ptr   <= ptr_adv(wr_ptr, cap);
        occ      <= occ + 1'b1;
        push_cnt <= sat_inc(push_cnt);
      end
      if (cmd.rd_store) begin
        rd_ptr  <= ptr_adv(rd_ptr, cap);
        occ     <= occ - 1'b1;
        pop_cnt <= sat_inc(pop_cnt);
      end
      if (cmd.count_overrun) begin
        overrun_cnt <= sat_inc(overrun_cnt);
      end
      if (cmd.count_underrun) begin
        underrun_cnt <= sat_inc(underrun_cnt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pend_took <= cmd.wr_store || cmd.rd_store;
      pend_pop  <= cmd.rd_store;
      pend_last <= req.burst_last;
    end
    if (cmd.load_rsp) begin
      rsp.sample_out     <= pend_pop ? WORD_W'(ram_rdata) : '0;
      rsp.accepted       <= pend_took;
      rsp.fill_level     <= FILL_W'(occ);
      rsp.underrun_total <= underrun_cnt;
      rsp.overrun_total  <= overrun_cnt;
      rsp.pushed_total   <= push_cnt;
      rsp.popped_total   <= pop_cnt;
      rsp.burst_end      <= pend_last;
    end
  end

endmodule

FILE: hdl/asfb_checker.sv
// Port-level checker for the audio sample FIFO bridge, bound to the top level.
// Depends on asfb_pkg and audio_sample_fifo_bridge_assert.svh.
`include "audio_sample_fifo_bridge_assert.svh"

module asfb_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input asfb_pkg::rsp_item_t rsp
);
  import asfb_pkg::*;

  logic req_fire;
  logic rsp_stall;

  assign req_fire  = req_valid && req_ready;
  assign rsp_stall = rsp_valid && !rsp_ready;

  `ASFB_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_stall, rsp_valid && $stable(rsp))
  `ASFB_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_fire, !req_ready)
  `ASFB_ASSERT_NOW(a_word_only_when_taken, clk, rst, rsp_valid && (rsp.sample_out != '0), rsp.accepted)
  `ASFB_ASSERT_NOW(a_fill_bound, clk, rst, rsp_valid, 32'(rsp.fill_level) <= DEPTH)

endmodule

bind audio_sample_fifo_bridge asfb_checker u_asfb_checker (.*);

FILE: bench/audio_sample_fifo_bridge_tb.sv
// Self-checking testbench for audio_sample_fifo_bridge: directed table, then random push/pop
// bursts over several capacity settings, with every result checked against the table or a ring predictor.
// Depends on asfb_pkg and the bridge RTL only.
`timescale 1ns / 1ps

module audio_sample_fifo_bridge_tb;
  import asfb_pkg::*;

  typedef struct {
    bit        is_cfg;
    int        cap;
    req_item_t it;
    bit        typed;
    rsp_item_t want;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_ready;
  req_item_t         req = '0;
  logic              rsp_valid;
  logic              rsp_ready = 1'b0;
  rsp_item_t         rsp;
  logic              cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]  cfg_wr_data = '0;

  // ring predictor state
  logic [WORD_W-1:0] ring_mem [DEPTH];
  logic [PTR_W-1:0]  ring_rd = '0;
  logic [PTR_W-1:0]  ring_wr = '0;
  logic [FILL_W-1:0] ring_fill = '0;
  logic [CFG_W-1:0]  cap_reg = '0;
  logic [CNT_W-1:0]  n_under = '0;
  logic [CNT_W-1:0]  n_over = '0;
  logic [CNT_W-1:0]  n_push = '0;
  logic [CNT_W-1:0]  n_pop = '0;

  rsp_item_t rsp_due [$];
  plan_row_t plan [$];

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int cap_writes = 0;
  int overruns_seen = 0;
  int underruns_seen = 0;
  bit tx_busy = 1'b0;
  bit rx_busy = 1'b1;
  int rx_wait = 0;

  audio_sample_fifo_bridge u_dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #4 clk = ~clk;

  function automatic logic [CNT_W-1:0] sat_up(logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic int ring_limit();
    if (cap_reg == 0) return 0;
    if (cap_reg == 1) return 2;
    if (cap_reg > DEPTH) return DEPTH;
    return int'(cap_reg);
  endfunction

  function automatic rsp_item_t ring_step(req_item_t it);
    rsp_item_t r;
    int lim;
    lim = ring_limit();
    r = '0;
    if (it.kind == KIND_PUSH) begin
      if (lim != 0) begin
        if (int'(ring_fill) >= lim) begin
          n_over = sat_up(n_over);
          overruns_seen++;
        end else begin
          ring_mem[ring_wr] = it.sample_in;
          ring_wr = (int'(ring_wr) + 1 >= lim) ? '0 : ring_wr + 1'b1;
          ring_fill = ring_fill + 1'b1;
          n_push = sat_up(n_push);
          r.accepted = 1'b1;
        end
      end
    end else if (lim == 0 || ring_fill == 0) begin
      n_under = sat_up(n_under);
      underruns_seen++;
    end else begin
      r.sample_out = ring_mem[ring_rd];
      ring_rd = (int'(ring_rd) + 1 >= lim) ? '0 : ring_rd + 1'b1;
      ring_fill = ring_fill - 1'b1;
      n_pop = sat_up(n_pop);
      r.accepted = 1'b1;
    end
    r.fill_level     = ring_fill;
    r.underrun_total = n_under;
    r.overrun_total  = n_over;
    r.pushed_total   = n_push;
    r.popped_total   = n_pop;
    r.burst_end      = it.burst_last;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH result %0d %s: got %h want %h", results_seen, what, got, want);
    errors++;
  endtask

  function automatic int next_gap();
    if ($urandom_range(0, 39) == 0) tx_busy = !tx_busy;
    return tx_busy ? $urandom_range(0, 12) : 0;
  endfunction

  // hold the item until taken, then record what it should produce
  task automatic put_item(req_item_t it, bit typed, rsp_item_t want);
    int gap;
    rsp_item_t exp_rsp;
    gap = next_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= it;
    do @(posedge clk); while (!req_ready);
    exp_rsp = ring_step(it);
    rsp_due.push_back(typed ? want : exp_rsp);
    items_sent++;
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    while (rsp_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(int cap);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= cap[CFG_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cap_reg = cap[CFG_W-1:0];
    ring_rd = '0;
    ring_wr = '0;
    ring_fill = '0;
    n_under = '0;
    n_over = '0;
    n_push = '0;
    n_pop = '0;
    cap_writes++;
  endtask

  function automatic void add_cfg(int cap);
    plan_row_t row;
    row = '{is_cfg: 1'b1, cap: cap, it: '0, typed: 1'b0, want: '0};
    plan.push_back(row);
  endfunction

  function automatic void add_item(logic kind, logic [31:0] word, logic last);
    plan_row_t row;
    row = '{is_cfg: 1'b0, cap: 0, it: '0, typed: 1'b0, want: '0};
    row.it.kind = kind;
    row.it.sample_in = word;
    row.it.burst_last = last;
    plan.push_back(row);
  endfunction

  function automatic void add_known(logic kind, logic [31:0] word, logic last,
                                    logic [31:0] out, logic acc, int fill,
                                    int und, int ovr, int psh, int pop);
    add_item(kind, word, last);
    plan[$].typed = 1'b1;
    plan[$].want.sample_out     = out;
    plan[$].want.accepted       = acc;
    plan[$].want.fill_level     = fill[FILL_W-1:0];
    plan[$].want.underrun_total = und;
    plan[$].want.overrun_total  = ovr;
    plan[$].want.pushed_total   = psh;
    plan[$].want.popped_total   = pop;
    plan[$].want.burst_end      = last;
  endfunction

  task automatic run_phase(int cap, int n);
    req_item_t it;
    int sent;
    int run_len;
    int push_pct;
    bit paused;
    logic k;
    write_capacity(cap);
    sent = 0;
    push_pct = 50;
    paused = 1'b0;
    while (sent < n) begin
      if (!paused && sent >= n / 2) begin
        settle();
        paused = 1'b1;
      end
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 2))
          0: push_pct = 25;
          1: push_pct = 50;
          default: push_pct = 75;
        endcase
      end
      if ($urandom_range(0, 9) == 0) begin
        it.kind = 1'($urandom_range(0, 1));
        it.sample_in = $urandom;
        it.burst_last = 1'($urandom_range(0, 1));
        put_item(it, 1'b0, '0);
        sent++;
      end else begin
        k = ($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP;
        run_len = $urandom_range(1, 8);
        for (int i = 0; i < run_len; i++) begin
          it.kind = k;
          it.sample_in = $urandom;
          it.burst_last = (i == run_len - 1);
          put_item(it, 1'b0, '0);
          sent++;
        end
      end
    end
  endtask

  always @(posedge clk) begin : rsp_side
    rsp_item_t w;
    if (!rst && rsp_valid && rsp_ready) begin
      results_seen++;
      if (rsp_due.size() == 0) begin
        report_mismatch("arrived with nothing expected", 32'd1, 32'd0);
      end else begin
        w = rsp_due.pop_front();
        if (rsp.sample_out !== w.sample_out)
          report_mismatch("sample_out", rsp.sample_out, w.sample_out);
        if (rsp.accepted !== w.accepted)
          report_mismatch("accepted", 32'(rsp.accepted), 32'(w.accepted));
        if (rsp.fill_level !== w.fill_level)
          report_mismatch("fill_level", 32'(rsp.fill_level), 32'(w.fill_level));
        if (rsp.underrun_total !== w.underrun_total)
          report_mismatch("underrun_total", rsp.underrun_total, w.underrun_total);
        if (rsp.overrun_total !== w.overrun_total)
          report_mismatch("overrun_total", rsp.overrun_total, w.overrun_total);
        if (rsp.pushed_total !== w.pushed_total)
          report_mismatch("pushed_total", rsp.pushed_total, w.pushed_total);
        if (rsp.popped_total !== w.popped_total)
          report_mismatch("popped_total", rsp.popped_total, w.popped_total);
        if (rsp.burst_end !== w.burst_end)
          report_mismatch("burst_end", 32'(rsp.burst_end), 32'(w.burst_end));
      end
      if ($urandom_range(0, 39) == 0) rx_busy = !rx_busy;
      rx_wait = rx_busy ? $urandom_range(0, 12) : 0;
    end
    if (rx_wait > 0) begin
      rx_wait--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  initial begin
    #4_000_000;
    $display("Timeout with %0d results still expected", rsp_due.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int directed;
    int cap_list [$];
    int spin;
    // ring disabled after reset
    add_known(KIND_PUSH, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0, 0, 0, 0, 0, 0);
    add_known(KIND_POP,  32'h0,         1'b0, 32'h0, 1'b0, 0, 1, 0, 0, 0);
    add_known(KIND_PUSH, 32'h0,         1'b0, 32'h0, 1'b0, 0, 1, 0, 0, 0);
    // capacity 1 acts as 2: fill, overrun, drain, underrun, wrap
    add_cfg(1);
    add_known(KIND_PUSH, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b1, 1, 0, 0, 1, 0);
    add_known(KIND_PUSH, 32'h0000_0000, 1'b1, 32'h0, 1'b1, 2, 0, 0, 2, 0);
    add_known(KIND_PUSH, 32'hA5A5_A5A5, 1'b0, 32'h0, 1'b0, 2, 0, 1, 2, 0);
    add_known(KIND_POP,  32'h5A5A_5A5A, 1'b0, 32'hFFFF_FFFF, 1'b1, 1, 0, 1, 2, 1);
    add_known(KIND_POP,  32'hFFFF_FFFF, 1'b0, 32'h0, 1'b1, 0, 0, 1, 2, 2);
    add_known(KIND_POP,  32'h0,         1'b1, 32'h0, 1'b0, 0, 1, 1, 2, 2);
    add_item(KIND_PUSH, 32'h8000_0001, 1'b0);
    add_item(KIND_POP,  32'h0,         1'b1);
    add_item(KIND_PUSH, 32'h0000_0001, 1'b1);
    add_item(KIND_POP,  32'hFFFF_FFFF, 1'b0);
    // oversized capacity clamps to the full depth
    add_cfg(8191);
    add_known(KIND_PUSH, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b1, 1, 0, 0, 1, 0);
    add_item(KIND_PUSH, 32'h1234_5678, 1'b1);
    add_known(KIND_POP,  32'h0,         1'b0, 32'h7FFF_FFFF, 1'b1, 1, 0, 0, 2, 1);
    add_item(KIND_POP,  32'h0,         1'b0);
    add_known(KIND_POP,  32'h0,         1'b1, 32'h0, 1'b0, 0, 1, 0, 2, 2);
    add_cfg(3);
    for (int i = 0; i < 4; i++) add_item(KIND_PUSH, 32'hC3C3_0000 + i, i == 3);
    for (int i = 0; i < 4; i++) add_item(KIND_POP, 32'h0, i == 3);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_capacity(plan[i].cap);
      else put_item(plan[i].it, plan[i].typed, plan[i].want);
    end
    directed = items_sent;

    cap_list = '{2, 4096, 5, 0, 16, 1, 8191, 7, 3, 64, 4095};
    foreach (cap_list[i]) run_phase(cap_list[i], 150);

    req_valid <= 1'b0;
    spin = 0;
    while (rsp_due.size() != 0 && spin < 2000) begin
      @(posedge clk);
      spin++;
    end
    repeat (8) @(posedge clk);
    if (rsp_due.size() != 0) begin
      report_mismatch("expected results never arrived", 32'(rsp_due.size()), 32'd0);
    end

    $display("Sent %0d items (%0d directed) over %0d capacity writes; %0d results checked.",
             items_sent, directed, cap_writes, results_seen);
    $display("Predicted %0d overruns and %0d underruns; %0d mismatches.",
             overruns_seen, underruns_seen, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
